// ===== src/ffr_pkg.sv =====
`default_nettype none
package ffr_pkg;

  // Configuration register map (register index taken from paddr[2]).
  localparam logic REG_APP_BASE = 1'b0;

  // Reset value of the application base address.
  localparam logic [31:0] APP_BASE_RESET = 32'h0800_8000;

  // Handshake bytes and response codes.
  localparam logic [7:0] HELLO_A  = 8'h01;
  localparam logic [7:0] HELLO_B  = 8'h03;
  localparam logic [7:0] RESP_OK  = 8'hFF;
  localparam logic [7:0] RESP_EOF = 8'hEF;

  // End-of-file marker characters.
  localparam logic [7:0] CHAR_E = 8'h45;
  localparam logic [7:0] CHAR_O = 8'h4F;
  localparam logic [7:0] CHAR_F = 8'h46;

  // CRC-16/MODBUS, reflected form.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Result kinds.
  localparam logic [1:0] KIND_WORD   = 2'd0;
  localparam logic [1:0] KIND_RESP   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Receive phases of the front end.
  typedef enum logic [2:0] {
    PH_HELLO1,
    PH_HELLO2,
    PH_LEN,
    PH_DATA,
    PH_CRCH,
    PH_CRCL,
    PH_OVER
  } phase_t;

  // States of the back end.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_READ,
    BK_WAIT,
    BK_WORD,
    BK_RESP,
    BK_EOF,
    BK_STAT
  } back_state_t;

  // Commands passed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_STATUS,
    CMD_EOF,
    CMD_DRAIN
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic        boot;
    logic [7:0]  len;
    logic [31:0] addr;
  } cmd_t;

  // Status returned from the back end to the front end.
  typedef struct packed {
    logic drain_done;
  } back_status_t;

  // One byte step of the CRC; eight shift steps on a 16-bit value.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/firmware_frame_receiver_core.sv =====
// Firmware frame receiver.
// Input channel: rx_byte with in_valid/in_ready, one request per received byte.
// Output channel: kind, flash_addr, flash_word, resp_byte, boot_app and last
// with out_valid/out_ready; last marks the final result caused by one byte.
// Configuration: APB-style port, register 0 (paddr 0) holds app_base_address.
// A byte is parsed in the cycle it is accepted. A handshake status is queued
// as a command. A good frame is handed through a two-entry command queue to the
// back end, which reads the payload store one byte per cycle in its read state,
// as the store has a single read port: each flash word takes four store reads,
// a wait for the registered read and one output load, then the response follows.
// An end-of-file frame gives its two results, the response and then the status.
// Bytes are taken at one per cycle except while a payload byte would overwrite
// a frame that is still being drained, or while the command queue is full.
// A stalled receiver holds the output register and, through the queue, stops
// the byte stream after at most two pending commands.
// Reset returns to waiting for the first handshake byte, sets app_base_address
// to its reset value and empties the queue; no clearing pass is needed.
`default_nettype none
module firmware_frame_receiver_core #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  rx_byte,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [31:0]      flash_addr,
  output logic [31:0]      flash_word,
  output logic [7:0]       resp_byte,
  output logic             boot_app,
  output logic             last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);

  logic [31:0]           app_base_address;
  logic                  q_push;
  ffr_pkg::cmd_t         q_data;
  logic                  q_pop;
  logic                  q_valid;
  ffr_pkg::cmd_t         q_head;
  logic                  q_full;
  ffr_pkg::back_status_t back_status;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [7:0]            ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [7:0]            ram_rdata;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ffr_pkg::REG_APP_BASE) ? app_base_address : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      app_base_address <= ffr_pkg::APP_BASE_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == ffr_pkg::REG_APP_BASE) begin
      app_base_address <= pwdata;
    end
  end

  ffr_front #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .rx_byte          (rx_byte),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .app_base_address (app_base_address),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_data           (q_data),
    .back_status      (back_status),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata)
  );

  ffr_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head),
    .full      (q_full)
  );

  ffr_ram #(
    .WIDTH (8),
    .DEPTH (PAYLOAD_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ffr_back #(
    .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .back_status (back_status),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .flash_addr  (flash_addr),
    .flash_word  (flash_word),
    .resp_byte   (resp_byte),
    .boot_app    (boot_app),
    .last        (last)
  );

endmodule
`default_nettype wire

// ===== src/ffr_ram.sv =====
`default_nettype none
module ffr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/ffr_cmd_queue.sv =====
`default_nettype none
module ffr_cmd_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ffr_pkg::cmd_t push_data,
  input  wire logic          pop,
  output logic               valid,
  output ffr_pkg::cmd_t      head,
  output logic               full
);

  ffr_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign valid = (count != 2'd0);
  assign full  = (count == 2'd2);
  assign head  = entries[rd_ptr];

  // Two-entry circular queue; the producer never pushes when full.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/ffr_front.sv =====
`default_nettype none
module ffr_front #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic [7:0]                       rx_byte,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [31:0]                      app_base_address,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output ffr_pkg::cmd_t                         q_data,
  input  wire ffr_pkg::back_status_t            back_status,
  output logic                                  ram_we,
  output logic [$clog2(PAYLOAD_DEPTH)-1:0]      ram_waddr,
  output logic [7:0]                            ram_wdata
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);
  localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);

  ffr_pkg::phase_t phase, phase_next;
  logic [7:0]  first_hello, first_hello_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  sent_crc_high, sent_crc_high_next;
  logic [31:0] write_address, write_address_next;
  logic [2:0]  eof_hit, eof_hit_next;
  logic [1:0]  drains, drains_next;
  logic        accept;
  logic        push_drain;

  // Payload bytes may not be written while a drain still reads the store.
  assign in_ready = !q_full && !((phase == ffr_pkg::PH_DATA) && (drains != 2'd0));
  assign accept   = in_valid && in_ready;

  assign ram_we    = accept && (phase == ffr_pkg::PH_DATA) && ({1'b0, byte_count} < DEPTH_W);
  assign ram_waddr = byte_count[AW-1:0];
  assign ram_wdata = rx_byte;

  assign push_drain = q_push && (q_data.op == ffr_pkg::CMD_DRAIN);

  // Byte parser: next phase, frame bookkeeping and command generation.
  always_comb begin
    phase_next         = phase;
    first_hello_next   = first_hello;
    frame_length_next  = frame_length;
    byte_count_next    = byte_count;
    running_crc_next   = running_crc;
    sent_crc_high_next = sent_crc_high;
    write_address_next = write_address;
    eof_hit_next       = eof_hit;
    q_push             = 1'b0;
    q_data             = '0;
    if (accept) begin
      case (phase)
        ffr_pkg::PH_HELLO1: begin
          first_hello_next = rx_byte;
          phase_next       = ffr_pkg::PH_HELLO2;
        end
        ffr_pkg::PH_HELLO2: begin
          q_push    = 1'b1;
          q_data.op = ffr_pkg::CMD_STATUS;
          if (first_hello == ffr_pkg::HELLO_A && rx_byte == ffr_pkg::HELLO_B) begin
            write_address_next = app_base_address;
            q_data.boot        = 1'b0;
            phase_next         = ffr_pkg::PH_LEN;
          end else begin
            q_data.boot = 1'b1;
            phase_next  = ffr_pkg::PH_OVER;
          end
        end
        ffr_pkg::PH_LEN: begin
          frame_length_next = rx_byte;
          byte_count_next   = 8'd0;
          running_crc_next  = ffr_pkg::CRC_INIT;
          eof_hit_next      = 3'b000;
          phase_next        = (rx_byte == 8'd0) ? ffr_pkg::PH_CRCH : ffr_pkg::PH_DATA;
        end
        ffr_pkg::PH_DATA: begin
          running_crc_next = ffr_pkg::crc_feed(running_crc, rx_byte);
          byte_count_next  = byte_count + 8'd1;
          if (byte_count == 8'd0) begin
            eof_hit_next[0] = (rx_byte == ffr_pkg::CHAR_E);
          end
          if (byte_count == 8'd1) begin
            eof_hit_next[1] = (rx_byte == ffr_pkg::CHAR_O);
          end
          if (byte_count == 8'd2) begin
            eof_hit_next[2] = (rx_byte == ffr_pkg::CHAR_F);
          end
          if (byte_count + 8'd1 == frame_length) begin
            phase_next = ffr_pkg::PH_CRCH;
          end
        end
        ffr_pkg::PH_CRCH: begin
          sent_crc_high_next = rx_byte;
          phase_next         = ffr_pkg::PH_CRCL;
        end
        ffr_pkg::PH_CRCL: begin
          phase_next = ffr_pkg::PH_LEN;
          if ({sent_crc_high, rx_byte} == running_crc) begin
            q_push = 1'b1;
            if (frame_length >= 8'd3 && (&eof_hit)) begin
              // End of file hands over to the application.
              q_data.op   = ffr_pkg::CMD_EOF;
              q_data.boot = 1'b1;
              phase_next  = ffr_pkg::PH_OVER;
            end else begin
              q_data.op          = ffr_pkg::CMD_DRAIN;
              q_data.len         = frame_length;
              q_data.addr        = write_address;
              write_address_next = write_address + {24'h000000, frame_length};
            end
          end
        end
        ffr_pkg::PH_OVER: begin
          phase_next = ffr_pkg::PH_OVER;
        end
        default: begin
          phase_next = ffr_pkg::PH_OVER;
        end
      endcase
    end
  end

  // Count of drain commands queued or still being carried out.
  always_comb begin
    drains_next = drains;
    if (push_drain && !back_status.drain_done) begin
      drains_next = drains + 2'd1;
    end else if (!push_drain && back_status.drain_done) begin
      drains_next = drains - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ffr_pkg::PH_HELLO1;
      first_hello   <= 8'd0;
      frame_length  <= 8'd0;
      byte_count    <= 8'd0;
      running_crc   <= ffr_pkg::CRC_INIT;
      sent_crc_high <= 8'd0;
      write_address <= ffr_pkg::APP_BASE_RESET;
      eof_hit       <= 3'b000;
      drains        <= 2'd0;
    end else begin
      phase         <= phase_next;
      first_hello   <= first_hello_next;
      frame_length  <= frame_length_next;
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      sent_crc_high <= sent_crc_high_next;
      write_address <= write_address_next;
      eof_hit       <= eof_hit_next;
      drains        <= drains_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/ffr_back.sv =====
`default_nettype none
module ffr_back #(
  parameter int PAYLOAD_DEPTH = 256
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             q_valid,
  input  wire ffr_pkg::cmd_t                    q_head,
  output logic                                  q_pop,
  output logic                                  ram_re,
  output logic [$clog2(PAYLOAD_DEPTH)-1:0]      ram_raddr,
  input  wire logic [7:0]                       ram_rdata,
  output ffr_pkg::back_status_t                 back_status,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            kind,
  output logic [31:0]                           flash_addr,
  output logic [31:0]                           flash_word,
  output logic [7:0]                            resp_byte,
  output logic                                  boot_app,
  output logic                                  last
);

  localparam int AW = $clog2(PAYLOAD_DEPTH);
  localparam logic [8:0] DEPTH_W = 9'(PAYLOAD_DEPTH);

  ffr_pkg::back_state_t state, state_next;
  logic [7:0]  cmd_len;
  logic [31:0] cmd_addr;
  logic        cmd_boot;
  logic [5:0]  word_idx;
  logic [1:0]  sub_idx;
  logic [7:0]  byte_pos;
  logic        oob;
  logic        rd_pend;
  logic [1:0]  rd_sub;
  logic        rd_oob;
  logic [31:0] word_buf;
  logic [5:0]  words;
  logic        can_load;
  logic        load;
  logic [1:0]  ld_kind;
  logic [31:0] ld_addr;
  logic [31:0] ld_word;
  logic [7:0]  ld_resp;
  logic        ld_boot;
  logic        ld_last;
  logic        word_step;

  assign words     = cmd_len[7:2];
  assign byte_pos  = {word_idx, sub_idx};
  assign oob       = ({1'b0, byte_pos} >= DEPTH_W);
  assign ram_raddr = byte_pos[AW-1:0];
  assign can_load  = !out_valid || out_ready;

  // Sequencer: next state and output register loads.
  always_comb begin
    state_next              = state;
    q_pop                   = 1'b0;
    ram_re                  = 1'b0;
    word_step               = 1'b0;
    back_status.drain_done  = 1'b0;
    load                    = 1'b0;
    ld_kind                 = ffr_pkg::KIND_WORD;
    ld_addr                 = 32'd0;
    ld_word                 = 32'd0;
    ld_resp                 = 8'd0;
    ld_boot                 = 1'b0;
    ld_last                 = 1'b0;
    case (state)
      ffr_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_head.op)
            ffr_pkg::CMD_DRAIN: begin
              state_next = (q_head.len[7:2] == 6'd0) ? ffr_pkg::BK_RESP : ffr_pkg::BK_READ;
            end
            ffr_pkg::CMD_EOF: state_next = ffr_pkg::BK_EOF;
            default:          state_next = ffr_pkg::BK_STAT;
          endcase
        end
      end
      ffr_pkg::BK_READ: begin
        ram_re = !oob;
        if (sub_idx == 2'd3) begin
          state_next = ffr_pkg::BK_WAIT;
        end
      end
      ffr_pkg::BK_WAIT: begin
        state_next = ffr_pkg::BK_WORD;
      end
      ffr_pkg::BK_WORD: begin
        if (can_load) begin
          load      = 1'b1;
          word_step = 1'b1;
          ld_kind   = ffr_pkg::KIND_WORD;
          ld_addr   = cmd_addr + {24'h000000, word_idx, 2'b00};
          ld_word   = word_buf;
          state_next = (word_idx == words - 6'd1) ? ffr_pkg::BK_RESP : ffr_pkg::BK_READ;
        end
      end
      ffr_pkg::BK_RESP: begin
        if (can_load) begin
          load                   = 1'b1;
          ld_kind                = ffr_pkg::KIND_RESP;
          ld_resp                = ffr_pkg::RESP_OK;
          ld_last                = 1'b1;
          back_status.drain_done = 1'b1;
          state_next             = ffr_pkg::BK_IDLE;
        end
      end
      ffr_pkg::BK_EOF: begin
        if (can_load) begin
          load       = 1'b1;
          ld_kind    = ffr_pkg::KIND_RESP;
          ld_resp    = ffr_pkg::RESP_EOF;
          state_next = ffr_pkg::BK_STAT;
        end
      end
      ffr_pkg::BK_STAT: begin
        if (can_load) begin
          load       = 1'b1;
          ld_kind    = ffr_pkg::KIND_STATUS;
          ld_boot    = cmd_boot;
          ld_last    = 1'b1;
          state_next = ffr_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = ffr_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ffr_pkg::BK_IDLE;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == ffr_pkg::BK_READ);
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Command capture, byte walk and word assembly.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_len  <= q_head.len;
      cmd_addr <= q_head.addr;
      cmd_boot <= q_head.boot;
      word_idx <= 6'd0;
      sub_idx  <= 2'd0;
    end
    if (state == ffr_pkg::BK_READ) begin
      sub_idx <= sub_idx + 2'd1;
    end
    if (word_step) begin
      word_idx <= word_idx + 6'd1;
    end
    rd_sub <= sub_idx;
    rd_oob <= oob;
    if (rd_pend) begin
      word_buf[{rd_sub, 3'b000} +: 8] <= rd_oob ? 8'h00 : ram_rdata;
    end
  end

  // Output register; fields of other kinds are zero.
  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= ld_kind;
      flash_addr <= ld_addr;
      flash_word <= ld_word;
      resp_byte  <= ld_resp;
      boot_app   <= ld_boot;
      last       <= ld_last;
    end
  end

endmodule
`default_nettype wire
